// ----- design/smrg_pkg.sv -----
// Shared constants, codes, mixing functions and interface structs of the range generator.
package smrg_pkg;

    localparam int WORD_W  = 32;
    localparam int STATE_W = 64;
    localparam int PIDX_W  = 16;
    localparam int CNT_W   = $clog2(WORD_W);
    localparam int CFG_IDX_W = 1;

    localparam logic [STATE_W-1:0] GOLDEN_INC = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [STATE_W-1:0] MIX_MUL_A  = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [STATE_W-1:0] MIX_MUL_B  = 64'h94d0_49bb_1331_11eb;
    localparam int MIX_SHIFT_A = 30;
    localparam int MIX_SHIFT_B = 27;
    localparam int MIX_SHIFT_C = 31;

    localparam logic [WORD_W:0] TWO_POW_WORD = {1'b1, {WORD_W{1'b0}}};

    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(3);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(WORD_W - 1);

    localparam logic [1:0] ACT_FULL   = 2'd0;
    localparam logic [1:0] ACT_RANGE  = 2'd1;
    localparam logic [1:0] ACT_RESEED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROOT_SEED     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_INDEX = 1'b1;

    typedef enum logic [1:0] {
        EMIT_ZERO    = 2'd0,
        EMIT_UNKNOWN = 2'd1,
        EMIT_SAMPLE  = 2'd2,
        EMIT_RANGE   = 2'd3
    } t_emit;

    typedef struct packed {
        logic       load;
        logic       seed_prep;
        logic       seed_add;
        logic       draw;
        logic       mix2;
        logic       mul;
        logic [1:0] mul_step;
        logic       finish_seed;
        logic       finish_draw;
        logic       div_init_t;
        logic       div_init_s;
        logic       div_step;
        logic       set_thresh;
        logic       emit;
        t_emit      emit_kind;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       unknown;
        logic       full_span;
        logic       reject;
    } t_dp_status;

    function automatic logic [STATE_W-1:0] mix_pre(input logic [STATE_W-1:0] v);
        return v ^ (v >> MIX_SHIFT_A);
    endfunction

    function automatic logic [STATE_W-1:0] mix_mid(input logic [STATE_W-1:0] v);
        return v ^ (v >> MIX_SHIFT_B);
    endfunction

    function automatic logic [STATE_W-1:0] mix_post(input logic [STATE_W-1:0] v);
        return v ^ (v >> MIX_SHIFT_C);
    endfunction

endpackage

// ----- design/smrg_datapath.sv -----
// Datapath: generator state, shared 32x32 multiplier, bit-serial remainder unit and output word.
module smrg_datapath import smrg_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wen,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [STATE_W-1:0]   i_cfg_wdata,
    input  logic [1:0]           i_action,
    input  logic [WORD_W-1:0]    i_range_max,
    input  logic [WORD_W-1:0]    i_range_min,
    input  logic                 i_max_unknown,
    input  logic                 i_min_unknown,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    output logic [WORD_W-1:0]    o_word,
    output logic                 o_word_unknown
);

    logic [STATE_W-1:0] r_root;
    logic [PIDX_W-1:0]  r_pidx;
    logic [STATE_W-1:0] r_state;
    logic [1:0]         r_action;
    logic               r_unknown;
    logic [WORD_W-1:0]  r_lo;
    logic [WORD_W-1:0]  r_span;
    logic [WORD_W:0]    r_thresh;
    logic [WORD_W-1:0]  r_sample;
    logic [STATE_W-1:0] r_ma;
    logic [STATE_W-1:0] r_mb;
    logic [STATE_W-1:0] r_prod;
    logic [STATE_W-1:0] r_acc;
    logic [WORD_W-1:0]  r_dvd;
    logic [WORD_W-1:0]  r_rem;
    logic [WORD_W-1:0]  r_word;
    logic               r_word_unknown;

    logic               w_swap;
    logic [WORD_W-1:0]  w_lo;
    logic [WORD_W-1:0]  w_hi;
    logic [STATE_W-1:0] w_draw_state;
    logic [STATE_W-1:0] w_final;
    logic [WORD_W-1:0]  w_sample_now;
    logic [WORD_W-1:0]  w_pa;
    logic [WORD_W-1:0]  w_pb;
    logic [WORD_W:0]    w_trial;
    logic [WORD_W:0]    w_diff;
    logic [PIDX_W:0]    w_pidx_inc;

    assign w_swap       = i_range_max < i_range_min;
    assign w_lo         = w_swap ? i_range_max : i_range_min;
    assign w_hi         = w_swap ? i_range_min : i_range_max;
    assign w_draw_state = r_state + GOLDEN_INC;
    assign w_final      = mix_post(r_acc);
    assign w_sample_now = w_final[STATE_W-1:WORD_W];
    assign w_trial      = {r_rem, r_dvd[WORD_W-1]};
    assign w_diff       = w_trial - {1'b0, r_span};
    assign w_pidx_inc   = {1'b0, r_pidx} + (PIDX_W+1)'(1);

    always_comb begin
        case (i_cmd.mul_step)
            2'd1: begin
                w_pa = r_ma[WORD_W-1:0];
                w_pb = r_mb[STATE_W-1:WORD_W];
            end
            2'd2: begin
                w_pa = r_ma[STATE_W-1:WORD_W];
                w_pb = r_mb[WORD_W-1:0];
            end
            default: begin
                w_pa = r_ma[WORD_W-1:0];
                w_pb = r_mb[WORD_W-1:0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root  <= '0;
            r_pidx  <= '0;
            r_state <= '0;
        end else begin
            if (i_cfg_wen) begin
                unique case (i_cfg_addr)
                    REG_ROOT_SEED:     r_root <= i_cfg_wdata;
                    REG_PROCESS_INDEX: r_pidx <= i_cfg_wdata[PIDX_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.draw) begin
                r_state <= w_draw_state;
            end else if (i_cmd.finish_seed) begin
                r_state <= w_final;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action  <= i_action;
            r_unknown <= i_max_unknown | i_min_unknown;
            r_lo      <= w_lo;
            r_span    <= w_hi - w_lo + WORD_W'(1);
        end
        if (i_cmd.seed_prep) begin
            r_ma <= GOLDEN_INC;
            r_mb <= STATE_W'(w_pidx_inc);
        end else if (i_cmd.seed_add) begin
            r_ma <= mix_pre(r_root + r_acc);
            r_mb <= MIX_MUL_A;
        end else if (i_cmd.draw) begin
            r_ma <= mix_pre(w_draw_state);
            r_mb <= MIX_MUL_A;
        end else if (i_cmd.mix2) begin
            r_ma <= mix_mid(r_acc);
            r_mb <= MIX_MUL_B;
        end
        if (i_cmd.mul) begin
            r_prod <= STATE_W'(w_pa) * STATE_W'(w_pb);
            case (i_cmd.mul_step)
                2'd0:    r_acc <= r_acc;
                2'd1:    r_acc <= r_prod;
                default: r_acc <= r_acc + {r_prod[WORD_W-1:0], {WORD_W{1'b0}}};
            endcase
        end
        if (i_cmd.finish_draw) begin
            r_sample <= w_sample_now;
        end
        if (i_cmd.div_init_t) begin
            r_dvd <= ~r_span + WORD_W'(1);
            r_rem <= '0;
        end else if (i_cmd.div_init_s) begin
            r_dvd <= w_sample_now;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[WORD_W-2:0], 1'b0};
            r_rem <= w_diff[WORD_W] ? w_trial[WORD_W-1:0] : w_diff[WORD_W-1:0];
        end
        if (i_cmd.set_thresh) begin
            r_thresh <= TWO_POW_WORD - {1'b0, r_rem};
        end
        if (i_cmd.emit) begin
            case (i_cmd.emit_kind)
                EMIT_UNKNOWN: begin
                    r_word         <= '0;
                    r_word_unknown <= 1'b1;
                end
                EMIT_SAMPLE: begin
                    r_word         <= r_sample;
                    r_word_unknown <= 1'b0;
                end
                EMIT_RANGE: begin
                    r_word         <= r_lo + r_rem;
                    r_word_unknown <= 1'b0;
                end
                default: begin
                    r_word         <= '0;
                    r_word_unknown <= 1'b0;
                end
            endcase
        end
    end

    assign o_status.action    = r_action;
    assign o_status.unknown   = r_unknown;
    assign o_status.full_span = (r_span == '0);
    assign o_status.reject    = {1'b0, w_sample_now} >= r_thresh;
    assign o_word             = r_word;
    assign o_word_unknown     = r_word_unknown;

endmodule

// ----- design/smrg_ctrl.sv -----
// Controller: sequences the mixer, the rejection loop and the remainder passes for each word.
module smrg_ctrl import smrg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0_0000_0000_0001,
        S_DECODE   = 13'b0_0000_0000_0010,
        S_SEED_MUL = 13'b0_0000_0000_0100,
        S_SEED_ADD = 13'b0_0000_0000_1000,
        S_DRAW     = 13'b0_0000_0001_0000,
        S_MUL_A    = 13'b0_0000_0010_0000,
        S_MIX2     = 13'b0_0000_0100_0000,
        S_MUL_B    = 13'b0_0000_1000_0000,
        S_FINISH   = 13'b0_0001_0000_0000,
        S_DIV_T    = 13'b0_0010_0000_0000,
        S_SET_T    = 13'b0_0100_0000_0000,
        S_DIV_S    = 13'b0_1000_0000_0000,
        S_EMIT     = 13'b1_0000_0000_0000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    t_emit            r_emit_kind, n_emit_kind;
    logic             r_out_valid, n_out_valid;
    logic             w_can_emit;

    assign w_can_emit = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_emit_kind = r_emit_kind;
        o_cmd       = '0;
        o_cmd.mul_step  = r_count[1:0];
        o_cmd.emit_kind = r_emit_kind;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_count = '0;
                unique case (i_status.action)
                    ACT_RESEED: begin
                        o_cmd.seed_prep = 1'b1;
                        n_state         = S_SEED_MUL;
                    end
                    ACT_RANGE: begin
                        if (i_status.unknown) begin
                            n_emit_kind = EMIT_UNKNOWN;
                            n_state     = S_EMIT;
                        end else if (i_status.full_span) begin
                            n_state = S_DRAW;
                        end else begin
                            o_cmd.div_init_t = 1'b1;
                            n_state          = S_DIV_T;
                        end
                    end
                    default: n_state = S_DRAW;
                endcase
            end
            S_SEED_MUL: begin
                o_cmd.mul = 1'b1;
                n_count   = r_count + CNT_W'(1);
                if (r_count == MUL_LAST) begin
                    n_count = '0;
                    n_state = S_SEED_ADD;
                end
            end
            S_SEED_ADD: begin
                o_cmd.seed_add = 1'b1;
                n_state        = S_MUL_A;
            end
            S_DRAW: begin
                o_cmd.draw = 1'b1;
                n_state    = S_MUL_A;
            end
            S_MUL_A: begin
                o_cmd.mul = 1'b1;
                n_count   = r_count + CNT_W'(1);
                if (r_count == MUL_LAST) begin
                    n_count = '0;
                    n_state = S_MIX2;
                end
            end
            S_MIX2: begin
                o_cmd.mix2 = 1'b1;
                n_state    = S_MUL_B;
            end
            S_MUL_B: begin
                o_cmd.mul = 1'b1;
                n_count   = r_count + CNT_W'(1);
                if (r_count == MUL_LAST) begin
                    n_count = '0;
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_status.action == ACT_RESEED) begin
                    o_cmd.finish_seed = 1'b1;
                    n_emit_kind       = EMIT_ZERO;
                    n_state           = S_EMIT;
                end else begin
                    o_cmd.finish_draw = 1'b1;
                    if (i_status.action == ACT_RANGE && !i_status.full_span) begin
                        if (i_status.reject) begin
                            n_state = S_DRAW;
                        end else begin
                            o_cmd.div_init_s = 1'b1;
                            n_state          = S_DIV_S;
                        end
                    end else begin
                        n_emit_kind = EMIT_SAMPLE;
                        n_state     = S_EMIT;
                    end
                end
            end
            S_DIV_T: begin
                o_cmd.div_step = 1'b1;
                n_count        = r_count + CNT_W'(1);
                if (r_count == DIV_LAST) begin
                    n_count = '0;
                    n_state = S_SET_T;
                end
            end
            S_SET_T: begin
                o_cmd.set_thresh = 1'b1;
                n_state          = S_DRAW;
            end
            S_DIV_S: begin
                o_cmd.div_step = 1'b1;
                n_count        = r_count + CNT_W'(1);
                if (r_count == DIV_LAST) begin
                    n_count     = '0;
                    n_emit_kind = EMIT_RANGE;
                    n_state     = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_can_emit) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_emit_kind <= EMIT_ZERO;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_emit_kind <= n_emit_kind;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ----- design/splitmix_random_range_generator.sv -----
// Top level of the splitmix64 random range generator: stream ports, controller and datapath.
// A full draw runs decode, draw, the first multiply, the second mix, the second multiply, finish and emit.
// A reseed multiplies and adds the seed before the mixer; a range draw below the full span adds the threshold
// remainder and the final remainder, and redraws each rejected sample; an unknown bound goes from decode to emit.
// The next word is accepted the cycle after a result enters the output register, which waits for room.
// Synchronous active-low reset clears the state, both registers and the output valid.
module splitmix_random_range_generator import smrg_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wen,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [STATE_W-1:0]   i_cfg_wdata,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [63:0]          i_s_axis_tdata,  // range_max, range_min
    input  logic [3:0]           i_s_axis_tuser,  // action[1:0], max_unknown, min_unknown
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [31:0]          o_m_axis_tdata,  // random_word
    output logic [0:0]           o_m_axis_tuser   // word_unknown
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_word_unknown;

    smrg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    smrg_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wen      (i_cfg_wen),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_action       (i_s_axis_tuser[1:0]),
        .i_range_max    (i_s_axis_tdata[31:0]),
        .i_range_min    (i_s_axis_tdata[63:32]),
        .i_max_unknown  (i_s_axis_tuser[2]),
        .i_min_unknown  (i_s_axis_tuser[3]),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_word         (o_m_axis_tdata),
        .o_word_unknown (w_word_unknown)
    );

    assign o_m_axis_tuser = w_word_unknown;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("Input ready stayed high after a word was accepted.");

    a_emit_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("Result written over a word that was not taken.");

    a_emit_shows_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |=> o_m_axis_tvalid)
        else $error("Output valid missing after a result was written.");

    a_unknown_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("Unknown result carries a nonzero word.");

endmodule

// ----- tb/tb_splitmix_random_range_generator.sv -----
// Self-checking testbench: directed and random draw, range and reseed words against a predictor and typed rows.
module tb_splitmix_random_range_generator import smrg_pkg::*; ();

    localparam logic [1:0]  ACT_SPARE     = 2'd3;
    localparam logic [63:0] SPAN_ALL      = 64'h1_0000_0000;
    localparam int          DIR_COUNT     = 20;
    localparam int          NUM_PHASES    = 5;
    localparam int          PHASE_ITEMS   = 316;
    localparam int          HOLD_AT       = 600;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          END_SETTLE    = 100;
    localparam int          REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] range_max;
        logic [31:0] range_min;
        logic        max_unk;
        logic        min_unk;
    } t_draw_req;

    typedef struct packed {
        logic [31:0] word;
        logic        unk;
    } t_rand_word;

    typedef struct packed {
        t_draw_req   req;
        logic        typed;
        t_rand_word  result;
    } t_dir_row;

    localparam t_dir_row DIR_ROWS [0:DIR_COUNT-1] = '{
        '{'{ACT_FULL,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0}, 1'b1, '{32'hE220_A839, 1'b0}},
        '{'{ACT_RANGE,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0}, 1'b1, '{32'h0000_0000, 1'b1}},
        '{'{ACT_RANGE,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1}, 1'b1, '{32'h0000_0000, 1'b1}},
        '{'{ACT_RANGE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1}, 1'b1, '{32'h0000_0000, 1'b1}},
        '{'{ACT_RANGE,  32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0}, 1'b1, '{32'h0000_0000, 1'b0}},
        '{'{ACT_RANGE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0}, 1'b1, '{32'hFFFF_FFFF, 1'b0}},
        '{'{ACT_RANGE,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, '{32'h0, 1'b0}},
        '{'{ACT_RANGE,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0}, 1'b0, '{32'h0, 1'b0}},
        '{'{ACT_RANGE,  32'h0000_0003, 32'h0000_0010, 1'b0, 1'b0}, 1'b0, '{32'h0, 1'b0}},
        '{'{ACT_RANGE,  32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, '{32'h0, 1'b0}},
        '{'{ACT_RANGE,  32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, '{32'h0, 1'b0}},
        '{'{ACT_RANGE,  32'hFFFF_FFFE, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, '{32'h0, 1'b0}},
        '{'{ACT_SPARE,  32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, '{32'h0, 1'b0}},
        '{'{ACT_RESEED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1}, 1'b1, '{32'h0000_0000, 1'b0}},
        '{'{ACT_FULL,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1}, 1'b0, '{32'h0, 1'b0}},
        '{'{ACT_SPARE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1}, 1'b0, '{32'h0, 1'b0}},
        '{'{ACT_RANGE,  32'd200,       32'd100,       1'b0, 1'b0}, 1'b0, '{32'h0, 1'b0}},
        '{'{ACT_RANGE,  32'd5,         32'd5,         1'b0, 1'b0}, 1'b1, '{32'd5, 1'b0}},
        '{'{ACT_RESEED, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0}, 1'b1, '{32'h0000_0000, 1'b0}},
        '{'{ACT_RANGE,  32'h0000_0010, 32'hFFFF_FFF0, 1'b0, 1'b0}, 1'b0, '{32'h0, 1'b0}}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wen;
    logic [CFG_IDX_W-1:0] i_cfg_addr;
    logic [STATE_W-1:0]   i_cfg_wdata;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [63:0]          i_s_axis_tdata;  // range_max, range_min
    logic [3:0]           i_s_axis_tuser;  // action[1:0], max_unknown, min_unknown
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [31:0]          o_m_axis_tdata;  // random_word
    logic [0:0]           o_m_axis_tuser;  // word_unknown

    splitmix_random_range_generator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    logic [63:0] gen_state;
    logic [63:0] seed_reg;
    logic [15:0] pidx_reg;
    t_rand_word  pending_words [$];

    logic [63:0] phase_seed [NUM_PHASES];
    logic [15:0] phase_pidx [NUM_PHASES];

    int  fail_count;
    int  sent_count;
    int  recv_count;
    int  full_count;
    int  range_count;
    int  unknown_count;
    int  reseed_count;
    int  reject_count;
    int  setting_count;
    bit  send_burst;
    bit  recv_burst;
    bit  hold_active;
    bit  hold_done;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int pick_between(input int lo_val, input int hi_val);
        return lo_val + int'($urandom % (hi_val - lo_val + 1));
    endfunction

    function automatic logic [63:0] splitmix_mix(input logic [63:0] z);
        logic [63:0] v;
        v = (z ^ (z >> MIX_SHIFT_A)) * MIX_MUL_A;
        v = (v ^ (v >> MIX_SHIFT_B)) * MIX_MUL_B;
        return v ^ (v >> MIX_SHIFT_C);
    endfunction

    function automatic logic [31:0] next_draw();
        logic [63:0] mixed;
        gen_state = gen_state + GOLDEN_INC;
        mixed = splitmix_mix(gen_state);
        return mixed[63:32];
    endfunction

    function automatic t_rand_word predict_word(input t_draw_req rq);
        t_rand_word  res;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] span;
        logic [63:0] limit;
        logic [63:0] sample;
        logic [63:0] sum;
        res.word = '0;
        res.unk  = 1'b0;
        case (rq.action)
            ACT_RESEED: begin
                gen_state = splitmix_mix(seed_reg + GOLDEN_INC * ({48'b0, pidx_reg} + 64'd1));
                reseed_count++;
            end
            ACT_RANGE: begin
                if (rq.max_unk || rq.min_unk) begin
                    res.unk = 1'b1;
                    unknown_count++;
                end else begin
                    range_count++;
                    if (rq.range_max < rq.range_min) begin
                        lo = {32'b0, rq.range_max};
                        hi = {32'b0, rq.range_min};
                    end else begin
                        lo = {32'b0, rq.range_min};
                        hi = {32'b0, rq.range_max};
                    end
                    span = hi - lo + 64'd1;
                    if (span == SPAN_ALL) begin
                        res.word = next_draw();
                    end else begin
                        limit  = SPAN_ALL - (SPAN_ALL % span);
                        sample = {32'b0, next_draw()};
                        while (sample >= limit) begin
                            reject_count++;
                            sample = {32'b0, next_draw()};
                        end
                        sum      = lo + sample % span;
                        res.word = sum[31:0];
                    end
                end
            end
            default: begin
                res.word = next_draw();
                full_count++;
            end
        endcase
        return res;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        i_cfg_wen   <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_wen <= 1'b0;
        if (idx == REG_ROOT_SEED) begin
            seed_reg = value;
        end else begin
            pidx_reg = value[15:0];
        end
        @(negedge i_clk);
    endtask

    task automatic send_request(input t_draw_req rq, input logic typed,
                                input t_rand_word typed_word);
        int         gap;
        t_rand_word want;
        gap = (send_burst || hold_active) ? 0 : pick_between(0, 17);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {rq.range_min, rq.range_max};
        i_s_axis_tuser  <= {rq.min_unk, rq.max_unk, rq.action};
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        want = predict_word(rq);
        if (typed) want = typed_word;
        pending_words = {pending_words, want};
        sent_count++;
        if (pick_between(0, 39) == 0) send_burst = !send_burst;
        @(negedge i_clk);
    endtask

    task automatic drain_words();
        i_s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(negedge i_clk);
    endtask

    initial begin : word_sink
        int         stall;
        t_rand_word want;
        i_m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (!hold_done && recv_count == HOLD_AT) begin
                hold_done   = 1'b1;
                hold_active = 1'b1;
                stall       = HOLD_CYCLES;
            end else begin
                stall = recv_burst ? 0 : pick_between(0, 17);
            end
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            hold_active = 1'b0;
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (o_m_axis_tvalid !== 1'b1);
            if (pending_words.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("Unexpected word %h, unknown flag %b.",
                             o_m_axis_tdata, o_m_axis_tuser[0]);
            end else begin
                want = pending_words.pop_front();
                if (o_m_axis_tdata !== want.word || o_m_axis_tuser[0] !== want.unk) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("Word %0d: expected %h/%b, got %h/%b.", recv_count,
                                 want.word, want.unk, o_m_axis_tdata, o_m_axis_tuser[0]);
                end
            end
            recv_count++;
            if (pick_between(0, 39) == 0) recv_burst = !recv_burst;
            @(negedge i_clk);
        end
    end

    initial begin
        #8_000_000;
        $display("Timeout with %0d words still expected.", pending_words.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        t_draw_req   rq;
        t_rand_word  blank;
        logic [31:0] lo;
        logic [31:0] hi;
        i_rst_n         = 1'b0;
        i_cfg_wen       = 1'b0;
        i_cfg_addr      = REG_ROOT_SEED;
        i_cfg_wdata     = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        gen_state       = '0;
        seed_reg        = '0;
        pidx_reg        = '0;
        blank           = '0;
        phase_seed[0] = 64'hFFFF_FFFF_FFFF_FFFF;  phase_pidx[0] = 16'hFFFF;
        phase_seed[1] = {$urandom, $urandom};     phase_pidx[1] = 16'($urandom);
        phase_seed[2] = 64'h0;                    phase_pidx[2] = 16'h0000;
        phase_seed[3] = {$urandom, $urandom};     phase_pidx[3] = 16'h0001;
        phase_seed[4] = 64'h8000_0000_0000_0000;  phase_pidx[4] = 16'h8000;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        write_reg(REG_ROOT_SEED, 64'h0);
        write_reg(REG_PROCESS_INDEX, 64'h0);
        setting_count++;

        for (int i = 0; i < DIR_COUNT; i++)
            send_request(DIR_ROWS[i].req, DIR_ROWS[i].typed, DIR_ROWS[i].result);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_words();
            write_reg(REG_ROOT_SEED, phase_seed[p]);
            write_reg(REG_PROCESS_INDEX, {48'b0, phase_pidx[p]});
            setting_count++;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                lo = $urandom;
                hi = $urandom;
                case (pick_between(0, 9))
                    0: hi = lo + 32'(pick_between(0, 15));
                    1: hi = lo;
                    2: begin
                        lo = 32'h0000_0000;
                        hi = 32'hFFFF_FFFF;
                    end
                    3: begin
                        lo = 32'(pick_between(0, 255));
                        hi = lo + 32'h8000_0000 + 32'(pick_between(0, 255));
                    end
                    4: begin
                        if (pick_between(0, 1) == 1) lo = 32'hFFFF_FFFF;
                        else lo = 32'h0000_0000;
                        if (pick_between(0, 1) == 1) hi = 32'hFFFF_FFFF;
                    end
                    default: ;
                endcase
                if (pick_between(0, 3) == 0) begin
                    rq.range_max = lo;
                    rq.range_min = hi;
                end else begin
                    rq.range_max = hi;
                    rq.range_min = lo;
                end
                case (pick_between(0, 19))
                    0, 1:       rq.action = ACT_RESEED;
                    2:          rq.action = ACT_SPARE;
                    3, 4, 5, 6,
                    7, 8:       rq.action = ACT_FULL;
                    default:    rq.action = ACT_RANGE;
                endcase
                if (n == 0) rq.action = ACT_RESEED;
                if (rq.action == ACT_RANGE) begin
                    rq.max_unk = (pick_between(0, 11) == 0);
                    rq.min_unk = (pick_between(0, 11) == 0);
                end else begin
                    rq.max_unk = 1'(pick_between(0, 1));
                    rq.min_unk = 1'(pick_between(0, 1));
                end
                send_request(rq, 1'b0, blank);
            end
        end

        drain_words();
        repeat (END_SETTLE) @(posedge i_clk);
        $display("Checked %0d of %0d words under %0d register settings: %0d full, %0d range,",
                 recv_count, sent_count, setting_count, full_count, range_count);
        $display("%0d unknown-bound, %0d reseed; %0d samples rejected; %0d mismatches.",
                 unknown_count, reseed_count, reject_count, fail_count);
        if (fail_count == 0 && pending_words.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/smrg_pkg.sv
design/smrg_datapath.sv
design/smrg_ctrl.sv
design/splitmix_random_range_generator.sv
tb/tb_splitmix_random_range_generator.sv
